[design/abe_pkg.sv]
// ---------------------------------------------------------------------------
// abe_pkg: shared codes and types for the array BST engine
// Operation and status codes, datapath select codes, and the
// command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package abe_pkg;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_PRE    = 3'd2;
  localparam logic [2:0] OP_IN     = 3'd3;
  localparam logic [2:0] OP_POST   = 3'd4;
  localparam logic [2:0] OP_LEVEL  = 3'd5;
  localparam logic [2:0] OP_CMPL   = 3'd6;

  localparam logic [2:0] ST_KEY     = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_CMPL    = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  // cursor load selects
  localparam logic [2:0] CUR_HOLD  = 3'd0;
  localparam logic [2:0] CUR_ZERO  = 3'd1;
  localparam logic [2:0] CUR_SRD   = 3'd2;
  localparam logic [2:0] CUR_QRD   = 3'd3;
  localparam logic [2:0] CUR_LEFT  = 3'd4;
  localparam logic [2:0] CUR_RIGHT = 3'd5;
  localparam logic [2:0] CUR_CHILD = 3'd6;

  // push data selects
  localparam logic [1:0] PSH_CUR   = 2'd0;
  localparam logic [1:0] PSH_LEFT  = 2'd1;
  localparam logic [1:0] PSH_RIGHT = 2'd2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic       accept;
    logic       clear_used;
    logic       key_wr_root;
    logic       key_wr_child;
    logic [2:0] cur_sel;
    logic       s_push;
    logic       s_pop;
    logic [1:0] s_sel;
    logic       q_push;
    logic       q_pop_tail;
    logic       q_pop_head;
    logic [1:0] q_sel;
    logic       q_rd_head;
    logic       clr_ptrs;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_key;
    logic       emit_last;
  } abe_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic key_marker;
    logic root_used;
    logic cur_used;
    logic left_used;
    logic right_used;
    logic sp_zero;
    logic qp_zero;
    logic head_at_tail;
    logic child_oob;
    logic child_used;
  } abe_sts_t;

endpackage

`default_nettype wire

[design/abe_datapath.sv]
// ---------------------------------------------------------------------------
// abe_datapath: storage, pointers and result register
// Key store, stack and queue memories, valid bits, cursor and
// the registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module abe_datapath
  import abe_pkg::*;
#(
  parameter int NODE_SLOTS = 63,
  parameter int KEY_BITS   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire abe_cmd_t               cmd,
  output abe_sts_t                    sts,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CW = IW + 2;
  localparam int PW = $clog2(NODE_SLOTS + 1);

  logic [KEY_BITS-1:0] key_mem [NODE_SLOTS];
  logic [IW-1:0]       stk_mem [NODE_SLOTS];
  logic [IW-1:0]       que_mem [NODE_SLOTS];

  logic [CW-1:0]         cur_r, cur_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [PW-1:0]         sp_r, sp_nxt, qp_r, qp_nxt, head_r, head_nxt;
  logic [NODE_SLOTS-1:0] used_r, used_nxt;
  logic [IW-1:0]         srd_r, qrd_r;
  logic [KEY_BITS-1:0]   krd_r;
  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic [31:0]           out_key_r;
  logic                  out_cmpl_r, out_last_r;

  logic [CW-1:0]       left, right, child;
  logic                less, complete;
  logic [KEY_BITS-1:0] key_in, kw_data;
  logic [63:0]         kx, ox;
  logic [PW-1:0]       spm1, qpm1, q_rd_addr;
  logic [IW-1:0]       s_wd, q_wd, kw_addr;

  function automatic logic used_at(input logic [CW-1:0] x,
                                   input logic [NODE_SLOTS-1:0] u);
    logic r;
    r = 1'b0;
    if (x < CW'(NODE_SLOTS)) r = u[x[IW-1:0]];
    return r;
  endfunction

  function automatic logic [IW-1:0] psh_data(input logic [1:0] sel, input logic [CW-1:0] c,
                                             input logic [CW-1:0] l, input logic [CW-1:0] r);
    logic [IW-1:0] d;
    case (sel)
      PSH_LEFT:  d = l[IW-1:0];
      PSH_RIGHT: d = r[IW-1:0];
      default:   d = c[IW-1:0];
    endcase
    return d;
  endfunction

  assign kx       = 64'($signed(in_tdata[34:3]));
  assign key_in   = kx[KEY_BITS-1:0];
  assign left     = (cur_r << 1) + CW'(1);
  assign right    = (cur_r << 1) + CW'(2);
  assign less     = $signed(key_r) < $signed(krd_r);
  assign child    = less ? left : right;
  assign complete = used_r[0] && (((used_r + NODE_SLOTS'(1)) & used_r) == '0);
  assign spm1     = sp_r - PW'(1);
  assign qpm1     = qp_r - PW'(1);
  assign q_rd_addr = cmd.q_rd_head ? head_r : qpm1;
  assign s_wd     = psh_data(cmd.s_sel, cur_r, left, right);
  assign q_wd     = psh_data(cmd.q_sel, cur_r, left, right);
  assign kw_data  = cmd.key_wr_root ? key_in : key_r;
  assign kw_addr  = cmd.key_wr_root ? '0 : child[IW-1:0];
  assign ox       = 64'($signed(krd_r));

  always_comb begin
    sts.can_emit     = !out_valid_r || out_tready;
    sts.key_marker   = (key_in == '1);
    sts.root_used    = used_r[0];
    sts.cur_used     = used_at(cur_r, used_r);
    sts.left_used    = used_at(left, used_r);
    sts.right_used   = used_at(right, used_r);
    sts.sp_zero      = (sp_r == '0);
    sts.qp_zero      = (qp_r == '0);
    sts.head_at_tail = (head_r == qp_r);
    sts.child_oob    = (child >= CW'(NODE_SLOTS));
    sts.child_used   = used_at(child, used_r);
  end

  always_comb begin
    case (cmd.cur_sel)
      CUR_ZERO:  cur_nxt = '0;
      CUR_SRD:   cur_nxt = CW'(srd_r);
      CUR_QRD:   cur_nxt = CW'(qrd_r);
      CUR_LEFT:  cur_nxt = left;
      CUR_RIGHT: cur_nxt = right;
      CUR_CHILD: cur_nxt = child;
      default:   cur_nxt = cur_r;
    endcase
    sp_nxt = sp_r;
    if (cmd.clr_ptrs)    sp_nxt = '0;
    else if (cmd.s_push) sp_nxt = sp_r + PW'(1);
    else if (cmd.s_pop)  sp_nxt = spm1;
    qp_nxt = qp_r;
    if (cmd.clr_ptrs)        qp_nxt = '0;
    else if (cmd.q_push)     qp_nxt = qp_r + PW'(1);
    else if (cmd.q_pop_tail) qp_nxt = qpm1;
    head_nxt = head_r;
    if (cmd.clr_ptrs)        head_nxt = '0;
    else if (cmd.q_pop_head) head_nxt = head_r + PW'(1);
    used_nxt = used_r;
    if (cmd.clear_used)        used_nxt = '0;
    else if (cmd.key_wr_root)  used_nxt[0] = 1'b1;
    else if (cmd.key_wr_child) used_nxt[child[IW-1:0]] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      sp_r        <= '0;
      qp_r        <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      sp_r   <= sp_nxt;
      qp_r   <= qp_nxt;
      head_r <= head_nxt;
      if (cmd.emit)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (cmd.accept) key_r <= key_in;
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_key_r    <= cmd.emit_key ? ox[31:0] : 32'd0;
      out_cmpl_r   <= (cmd.emit_status == ST_CMPL) && complete;
      out_last_r   <= cmd.emit_last;
    end
  end

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (cmd.key_wr_root || cmd.key_wr_child) key_mem[kw_addr] <= kw_data;
    krd_r <= key_mem[cur_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.s_push) stk_mem[sp_r[IW-1:0]] <= s_wd;
    srd_r <= stk_mem[spm1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.q_push) que_mem[qp_r[IW-1:0]] <= q_wd;
    qrd_r <= que_mem[q_rd_addr[IW-1:0]];
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_cmpl_r, out_key_r, out_status_r};

endmodule

`default_nettype wire

[design/abe_ctrl.sv]
// ---------------------------------------------------------------------------
// abe_ctrl: operation sequencer
// Steps clear, insert, traversal and completeness requests over the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module abe_ctrl
  import abe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic [2:0] in_op,
  input  wire abe_sts_t sts,
  output abe_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ONE     = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_CMP = 4'd3;
  localparam logic [3:0] S_T_KEY   = 4'd4;
  localparam logic [3:0] S_T_EMIT  = 4'd5;
  localparam logic [3:0] S_T_PUSH2 = 4'd6;
  localparam logic [3:0] S_T_POP   = 4'd7;
  localparam logic [3:0] S_T_CUR   = 4'd8;
  localparam logic [3:0] S_IN_DESC = 4'd9;
  localparam logic [3:0] S_PO_REC  = 4'd10;
  localparam logic [3:0] S_PO_PSHR = 4'd11;
  localparam logic [3:0] S_PO_POP  = 4'd12;
  localparam logic [3:0] S_PO_CUR  = 4'd13;
  localparam logic [3:0] S_PO_OUT  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [2:0] resp_r, resp_nxt;
  logic       lst;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    op_nxt    = op_r;
    resp_nxt  = resp_r;
    lst       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          op_nxt     = in_op;
          unique case (in_op) inside
            OP_CLEAR: begin
              cmd.clear_used = 1'b1;
              resp_nxt       = ST_CLEARED;
              state_nxt      = S_ONE;
            end
            OP_INSERT: begin
              if (sts.key_marker) begin
                resp_nxt  = ST_DROPPED;
                state_nxt = S_ONE;
              end else if (!sts.root_used) begin
                cmd.key_wr_root = 1'b1;
                resp_nxt        = ST_STORED;
                state_nxt       = S_ONE;
              end else begin
                cmd.cur_sel = CUR_ZERO;
                state_nxt   = S_INS_RD;
              end
            end
            OP_PRE, OP_IN, OP_POST, OP_LEVEL: begin
              if (!sts.root_used) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_ONE;
              end else begin
                cmd.cur_sel  = CUR_ZERO;
                cmd.clr_ptrs = 1'b1;
                if (in_op == OP_IN)        state_nxt = S_IN_DESC;
                else if (in_op == OP_POST) state_nxt = S_PO_REC;
                else                       state_nxt = S_T_KEY;
              end
            end
            OP_CMPL: begin
              resp_nxt  = ST_CMPL;
              state_nxt = S_ONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ONE: begin
        if (sts.can_emit) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = resp_r;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_INS_RD: state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (sts.child_oob) begin
          resp_nxt  = ST_DROPPED;
          state_nxt = S_ONE;
        end else if (!sts.child_used) begin
          cmd.key_wr_child = 1'b1;
          resp_nxt         = ST_STORED;
          state_nxt        = S_ONE;
        end else begin
          cmd.cur_sel = CUR_CHILD;
          state_nxt   = S_INS_RD;
        end
      end
      S_T_KEY: state_nxt = S_T_EMIT;
      S_T_EMIT: begin
        if (sts.can_emit) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_KEY;
          cmd.emit_key    = 1'b1;
          case (op_r)
            OP_PRE: begin
              lst        = sts.sp_zero && !sts.left_used && !sts.right_used;
              cmd.s_push = !lst && sts.right_used;
              cmd.s_sel  = PSH_RIGHT;
              state_nxt  = lst ? S_IDLE : S_T_PUSH2;
            end
            OP_LEVEL: begin
              lst        = sts.head_at_tail && !sts.left_used && !sts.right_used;
              cmd.q_push = !lst && sts.left_used;
              cmd.q_sel  = PSH_LEFT;
              state_nxt  = lst ? S_IDLE : S_T_PUSH2;
            end
            OP_IN: begin
              lst         = sts.sp_zero && !sts.right_used;
              cmd.cur_sel = CUR_RIGHT;
              state_nxt   = lst ? S_IDLE : S_IN_DESC;
            end
            default: begin
              lst       = sts.qp_zero;
              state_nxt = lst ? S_IDLE : S_PO_OUT;
            end
          endcase
          cmd.emit_last = lst;
        end
      end
      S_T_PUSH2: begin
        if (op_r == OP_PRE) begin
          cmd.s_push = sts.left_used;
          cmd.s_sel  = PSH_LEFT;
        end else begin
          cmd.q_push = sts.right_used;
          cmd.q_sel  = PSH_RIGHT;
        end
        state_nxt = S_T_POP;
      end
      S_T_POP: begin
        if (op_r == OP_PRE) begin
          cmd.s_pop = 1'b1;
        end else begin
          cmd.q_pop_head = 1'b1;
          cmd.q_rd_head  = 1'b1;
        end
        state_nxt = S_T_CUR;
      end
      S_T_CUR: begin
        cmd.cur_sel = (op_r == OP_PRE || op_r == OP_IN) ? CUR_SRD : CUR_QRD;
        state_nxt   = S_T_KEY;
      end
      S_IN_DESC: begin
        if (sts.cur_used) begin
          cmd.s_push  = 1'b1;
          cmd.s_sel   = PSH_CUR;
          cmd.cur_sel = CUR_LEFT;
        end else begin
          cmd.s_pop = 1'b1;
          state_nxt = S_T_CUR;
        end
      end
      S_PO_REC: begin
        cmd.q_push = 1'b1;
        cmd.q_sel  = PSH_CUR;
        cmd.s_push = sts.left_used;
        cmd.s_sel  = PSH_LEFT;
        state_nxt  = S_PO_PSHR;
      end
      S_PO_PSHR: begin
        cmd.s_push = sts.right_used;
        cmd.s_sel  = PSH_RIGHT;
        state_nxt  = S_PO_POP;
      end
      S_PO_POP: begin
        if (!sts.sp_zero) begin
          cmd.s_pop = 1'b1;
          state_nxt = S_PO_CUR;
        end else begin
          state_nxt = S_PO_OUT;
        end
      end
      S_PO_CUR: begin
        cmd.cur_sel = CUR_SRD;
        state_nxt   = S_PO_REC;
      end
      S_PO_OUT: begin
        cmd.q_pop_tail = 1'b1;
        state_nxt      = S_T_CUR;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    resp_r <= resp_nxt;
  end

endmodule

`default_nettype wire

[design/array_bst_engine_top.sv]
// Array BST engine: clear, insert, four traversals and a completeness query.
// Clear, query and empty-tree requests pass from idle to a single response
// state; insert reads and compares each tree level walked. Traversals emit keys
// in pre, in and level order directly; postorder replays a recorded queue in reverse.
// One request in flight at a time. Synchronous active-low reset empties the
// tree (valid bits are flops, no sweep) and drops any pending result.
`default_nettype none

module array_bst_engine_top
  import abe_pkg::*;
#(
  parameter int NODE_SLOTS = 63,
  parameter int KEY_BITS   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] op, [34:3] key, rest zero
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [2:0] status, [34:3] out_key,
                                                  // [35] is_complete, rest zero
  output logic                        out_tlast
);

  abe_cmd_t cmd;
  abe_sts_t sts;

  // controller: walks and traversal sequencing
  abe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tdata[2:0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: key store, stack, queue and the result register
  abe_datapath #(
    .NODE_SLOTS (NODE_SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the array BST engine
// Drives clear, insert, traversal and completeness requests over the input
// stream, predicts every result from a local copy of the tree and checks
// each accepted result in order against the expected queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import abe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 63;
  localparam logic [2:0] OP_NONE = 3'd7;   // unused code, gives no results

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key;
    logic        cmpl;
    logic        last;
  } bst_result_t;

  // Local tree copy and expected result queue
  class bst_scoreboard;
    logic [31:0] keys[SLOTS];
    bit          used[SLOTS];
    bst_result_t pending[$];
    int          mismatches;

    function void push_res(logic [2:0] st, logic [31:0] k, logic c);
      bst_result_t r;
      r.status = st;
      r.key    = k;
      r.cmpl   = c;
      r.last   = 1'b0;
      pending.push_back(r);
    endfunction

    function bit used_at(int i);
      return i < SLOTS && used[i];
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] k);
      int  cur;
      int  c;
      int  stk[$];
      int  order[$];
      int  n0;
      bit  gap;
      bit  ok;
      n0 = pending.size();
      case (op)
        OP_CLEAR: begin
          foreach (used[i]) used[i] = 0;
          push_res(ST_CLEARED, 0, 0);
        end
        OP_INSERT: begin
          if (k == 32'hffff_ffff) begin
            push_res(ST_DROPPED, 0, 0);
          end else if (!used[0]) begin
            keys[0] = k; used[0] = 1;
            push_res(ST_STORED, 0, 0);
          end else begin
            cur = 0;
            forever begin
              c = 2 * cur + (($signed(k) < $signed(keys[cur])) ? 1 : 2);
              if (c >= SLOTS) begin
                push_res(ST_DROPPED, 0, 0);
                break;
              end
              if (!used[c]) begin
                keys[c] = k; used[c] = 1;
                push_res(ST_STORED, 0, 0);
                break;
              end
              cur = c;
            end
          end
        end
        OP_PRE, OP_IN, OP_POST, OP_LEVEL: begin
          if (!used[0]) begin
            push_res(ST_EMPTY, 0, 0);
          end else begin
            if (op == OP_PRE) begin
              stk.push_back(0);
              while (stk.size() > 0) begin
                cur = stk.pop_back();
                order.push_back(cur);
                if (used_at(2 * cur + 2)) stk.push_back(2 * cur + 2);
                if (used_at(2 * cur + 1)) stk.push_back(2 * cur + 1);
              end
            end else if (op == OP_IN) begin
              cur = 0;
              forever begin
                while (used_at(cur)) begin
                  stk.push_back(cur);
                  cur = 2 * cur + 1;
                end
                if (stk.size() == 0) break;
                cur = stk.pop_back();
                order.push_back(cur);
                cur = 2 * cur + 2;
              end
            end else if (op == OP_POST) begin
              stk.push_back(0);
              while (stk.size() > 0) begin
                cur = stk.pop_back();
                order.push_front(cur);
                if (used_at(2 * cur + 1)) stk.push_back(2 * cur + 1);
                if (used_at(2 * cur + 2)) stk.push_back(2 * cur + 2);
              end
            end else begin
              stk.push_back(0);
              while (stk.size() > 0) begin
                cur = stk.pop_front();
                order.push_back(cur);
                if (used_at(2 * cur + 1)) stk.push_back(2 * cur + 1);
                if (used_at(2 * cur + 2)) stk.push_back(2 * cur + 2);
              end
            end
            foreach (order[i]) push_res(ST_KEY, keys[order[i]], 0);
          end
        end
        OP_CMPL: begin
          gap = 0; ok = 1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!used[i]) gap = 1;
            else if (gap) ok = 0;
          end
          push_res(ST_CMPL, 0, used[0] && ok);
        end
        default: ;
      endcase
      if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(bst_result_t got);
      bst_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result st=%0d key=%h", got.status, got.key);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d key=%h cmpl=%b last=%b, got st=%0d key=%h cmpl=%b last=%b",
                   want.status, want.key, want.cmpl, want.last,
                   got.status, got.key, got.cmpl, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  bst_scoreboard tree_sb = new();
  int send_idle_pct;   // sender idle chance, percent
  int recv_idle_pct;   // receiver stall chance, percent

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  array_bst_engine_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // Receiver: random stalls, checks each accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tree_sb.check_result({out_tdata[2:0], out_tdata[34:3], out_tdata[35], out_tlast});
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // One request: random idle gap, then hold valid until accepted.
  // Valid is only dropped when the next request is not driven this step.
  task automatic send_request(logic [2:0] op, logic [31:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, k, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tree_sb.note_request(op, k);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tree_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
      2: return 32'hffff_ffff;
      default: return $urandom_range(40) - 20;
    endcase
  endfunction

  // Random phase: mostly inserts building trees, traversals and queries in between
  task automatic random_phase(int count);
    logic [2:0] op;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 4) op = OP_CLEAR;
      else if (r < 55) op = OP_INSERT;
      else if (r < 62) op = OP_CMPL;
      else if (r < 64) op = OP_NONE;
      else op = 3'($urandom_range(OP_LEVEL, OP_PRE));
      send_request(op, pick_key());
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tree traversals, extreme keys, marker, full path, unused op
    send_request(OP_PRE, 0);
    send_request(OP_IN, 0);
    send_request(OP_POST, 0);
    send_request(OP_LEVEL, 0);
    send_request(OP_CMPL, 0);
    send_request(OP_INSERT, 32'hffff_ffff);
    send_request(OP_INSERT, 32'd0);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h7fff_ffff);
    send_request(OP_CMPL, 0);
    send_request(OP_INSERT, 32'd0);          // equal key goes right
    send_request(OP_INSERT, 32'h5555_5555);
    send_request(OP_INSERT, 32'haaaa_aaaa);
    send_request(OP_PRE, 0);
    send_request(OP_IN, 0);
    send_request(OP_POST, 0);
    send_request(OP_LEVEL, 0);
    send_request(OP_CMPL, 0);
    send_request(OP_NONE, 32'h1234_5678);
    for (int i = 0; i < 6; i++) send_request(OP_INSERT, 32'h7fff_ffff); // runs off the array
    send_request(OP_LEVEL, 0);
    send_request(OP_CLEAR, 0);
    drain_results();

    send_idle_pct = 36; recv_idle_pct = 81;
    random_phase(150);
    drain_results();   // sender waits for every result
    send_idle_pct = 81; recv_idle_pct = 36;
    random_phase(140);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(140);
    drain_results();

    if (tree_sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
